// ===== rtl/ets_pkg.sv =====
`default_nettype none

package ets_pkg;

    localparam int DEPTH   = 2048;
    localparam int WINDOW  = 256;
    localparam int HALF    = WINDOW / 2;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DATA_W  = 16;
    localparam int START_W = 11;

    localparam logic [DATA_W-1:0] FILL_VALUE  = 16'h4040;
    localparam logic [DATA_W-1:0] LEVEL_RESET = 16'd3584;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } ets_state_t;

    typedef struct packed {
        addr_t wp;
        cnt_t  fill;
        data_t level;
    } ring_info_t;

    function automatic logic [START_W-1:0] to_start(input addr_t a);
        logic [ADDR_W+START_W-1:0] w;
        begin
            w = {{START_W{1'b0}}, a};
            return w[START_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ets_ram.sv =====
`default_nettype none

module ets_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ets_search.sv =====
`default_nettype none

module ets_search (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire ets_pkg::ring_info_t         ring,
    input  wire ets_pkg::data_t              rd_data,
    output ets_pkg::addr_t                   rd_addr,
    output logic                             busy,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ets_pkg::START_W-1:0]      m_start,
    output logic                             m_found
);

    ets_pkg::ets_state_t state_reg, state_next;
    ets_pkg::addr_t      rd_addr_reg, rd_addr_next;
    ets_pkg::cnt_t       rem_reg, rem_next;
    logic                dv_reg, dv_next;
    ets_pkg::addr_t      q_addr_reg, q_addr_next;
    logic                q_last_reg, q_last_next;
    logic                first_reg, first_next;
    ets_pkg::data_t      prev_reg, prev_next;
    ets_pkg::addr_t      res_start_reg, res_start_next;
    logic                res_found_reg, res_found_next;
    logic                m_valid_reg, m_valid_next;
    logic [ets_pkg::START_W-1:0] m_start_reg, m_start_next;
    logic                m_found_reg, m_found_next;

    ets_pkg::data_t      cur_val;
    logic                rising;
    logic                falling;

    always_comb begin
        cur_val = ({1'b0, q_addr_reg} < ring.fill) ? rd_data : ets_pkg::FILL_VALUE;
        rising  = (cur_val <= ring.level) && (ring.level < prev_reg);
        falling = (prev_reg < ring.level) && (ring.level <= cur_val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ets_pkg::ST_IDLE;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
        rd_addr_reg   <= rd_addr_next;
        rem_reg       <= rem_next;
        q_addr_reg    <= q_addr_next;
        q_last_reg    <= q_last_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        res_start_reg <= res_start_next;
        res_found_reg <= res_found_next;
        m_start_reg   <= m_start_next;
        m_found_reg   <= m_found_next;
    end

    always_comb begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        rem_next       = rem_reg;
        dv_next        = 1'b0;
        q_addr_next    = q_addr_reg;
        q_last_next    = q_last_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        res_start_next = res_start_reg;
        res_found_next = res_found_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_start_next   = m_start_reg;
        m_found_next   = m_found_reg;

        unique case (state_reg)
            ets_pkg::ST_IDLE: begin
                if (start) begin
                    rd_addr_next = ring.wp - ets_pkg::ADDR_W'(ets_pkg::HALF);
                    rem_next     = ets_pkg::CNT_W'(ets_pkg::DEPTH - ets_pkg::HALF + 1);
                    first_next   = 1'b1;
                    state_next   = ets_pkg::ST_SCAN;
                end
            end
            ets_pkg::ST_SCAN: begin
                if (rem_reg != '0) begin
                    rd_addr_next = rd_addr_reg - 1'b1;
                    rem_next     = rem_reg - 1'b1;
                    dv_next      = 1'b1;
                    q_addr_next  = rd_addr_reg;
                    q_last_next  = (rem_reg == ets_pkg::CNT_W'(1));
                end
                if (dv_reg) begin
                    prev_next  = cur_val;
                    first_next = 1'b0;
                    if (!first_reg && (rising || falling)) begin
                        res_start_next = q_addr_reg - ets_pkg::ADDR_W'(ets_pkg::HALF);
                        res_found_next = 1'b1;
                        state_next     = ets_pkg::ST_HOLD;
                    end else if (q_last_reg) begin
                        res_start_next = ring.wp - ets_pkg::ADDR_W'(ets_pkg::WINDOW);
                        res_found_next = 1'b0;
                        state_next     = ets_pkg::ST_HOLD;
                    end
                end
            end
            ets_pkg::ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_start_next = ets_pkg::to_start(res_start_reg);
                    m_found_next = res_found_reg;
                    state_next   = ets_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ets_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_addr_reg;
    assign busy    = (state_reg != ets_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_start = m_start_reg;
    assign m_found = m_found_reg;

endmodule

`default_nettype wire

// ===== rtl/edge_trigger_sample_ring.sv =====
// Channel | Direction | tdata (low bit up)        | tuser
// s_      | in        | sample[15:0]              | req_type
// m_      | out       | read_start[10:0], 5'b0    | found
// cfg_    | in        | level[15:0]               | -
//
// Sample stores may follow every cycle while no trigger search is running.
// A trigger search makes one ring read per cycle through the single port of the
// sample memory; s_tready is low meanwhile.
// Reset clears pointer and fill count; unwritten entries read as 0x4040, no sweep.
// Stores are still taken while a result waits on a stalled m_ channel; a later
// search then holds s_tready low until that waiting result is transferred.
`default_nettype none

module edge_trigger_sample_ring (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample[15:0]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_start[10:0], zeros[15:11]
    output logic             m_tuser,   // found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // level[15:0]
);

    ets_pkg::addr_t      wp_reg, wp_next;
    ets_pkg::cnt_t       fill_reg, fill_next;
    ets_pkg::data_t      level_reg, level_next;
    ets_pkg::ring_info_t ring;
    ets_pkg::addr_t      srch_addr;
    ets_pkg::addr_t      ram_addr;
    ets_pkg::data_t      ram_rdata;
    logic                busy;
    logic                take;
    logic                wr_en;
    logic                srch_start;
    logic [ets_pkg::START_W-1:0] res_start;

    assign take       = s_tvalid && s_tready;
    assign wr_en      = take && !s_tuser;
    assign srch_start = take && s_tuser;
    assign s_tready   = !busy;
    assign cfg_ready  = 1'b1;

    always_comb begin
        wp_next    = wr_en ? wp_reg + 1'b1 : wp_reg;
        fill_next  = (wr_en && (fill_reg != ets_pkg::CNT_W'(ets_pkg::DEPTH))) ?
                     fill_reg + 1'b1 : fill_reg;
        level_next = cfg_valid ? cfg_data : level_reg;
        ram_addr   = busy ? srch_addr : wp_reg;
        ring.wp    = wp_reg;
        ring.fill  = fill_reg;
        ring.level = level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            level_reg <= ets_pkg::LEVEL_RESET;
        end else begin
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            level_reg <= level_next;
        end
    end

    ets_ram #(
        .WIDTH(ets_pkg::DATA_W),
        .DEPTH(ets_pkg::DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .addr (ram_addr),
        .wdata(s_tdata),
        .rdata(ram_rdata)
    );

    ets_search u_search (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (srch_start),
        .ring   (ring),
        .rd_data(ram_rdata),
        .rd_addr(srch_addr),
        .busy   (busy),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .m_start(res_start),
        .m_found(m_tuser)
    );

    assign m_tdata = {(16 - ets_pkg::START_W)'(0), res_start};

endmodule

`default_nettype wire

// ===== rtl/ets_chk.sv =====
`default_nettype none

module ets_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_search_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during trigger search");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("result padding not zero");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind edge_trigger_sample_ring ets_chk u_chk (.*);

`default_nettype wire
